### design/boost_energy_integral_duty_control_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the energy duty controller.
// ----------------------------------------------------------------------------
`ifndef BOOST_ENERGY_INTEGRAL_DUTY_CONTROL_UNIT_MACROS_SVH
`define BOOST_ENERGY_INTEGRAL_DUTY_CONTROL_UNIT_MACROS_SVH

// same-cycle implication
`define BEIDC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("beidc assertion failed");

// next-cycle implication
`define BEIDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("beidc assertion failed");

`endif

### design/beidc_pkg.sv
// ----------------------------------------------------------------------------
// beidc_pkg
// Types, constants and micro-program for the energy duty controller.
// ----------------------------------------------------------------------------
package beidc_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned MEAS_W = 24;
  localparam int unsigned CFG_W  = 40;
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned PC_W   = 5;

  localparam logic [PC_W-1:0]   LAST_PC  = 5'd28;
  localparam logic [DUTY_W-1:0] DUTY_ONE = 16'd32768;

  localparam logic signed [WORD_W-1:0] W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] W_MIN = 64'sh8000_0000_0000_0000;

  localparam logic signed [WORD_W-1:0] K1_RST  = 64'sd64960035158394;
  localparam logic signed [WORD_W-1:0] K2_RST  = 64'sd46976204784;
  localparam logic signed [WORD_W-1:0] K3_RST  = -64'sd45091775829676433;
  localparam logic [CFG_W-1:0]         DT_RST  = 40'd10995116;
  localparam logic [CFG_W-1:0]         CAP_RST = 40'd164926744;
  localparam logic [CFG_W-1:0]         IND_RST = 40'd51677047;

  typedef enum logic [IDX_W-1:0] {
    CFG_K1  = 3'd0,
    CFG_K2  = 3'd1,
    CFG_K3  = 3'd2,
    CFG_DT  = 3'd3,
    CFG_CAP = 3'd4,
    CFG_IND = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_ADD, OP_SUB} op_e;

  typedef enum logic [4:0] {
    SRC_T0, SRC_T1, SRC_T2, SRC_ES, SRC_ZERO, SRC_ONE,
    SRC_VOUT, SRC_VIN, SRC_VDO, SRC_VDI, SRC_IL, SRC_IO, SRC_VREF,
    SRC_K1, SRC_K2, SRC_K3, SRC_DT, SRC_CAP, SRC_IND
  } src_e;

  typedef enum logic [1:0] {SH_0, SH_23, SH_40, SH_41} shift_e;

  typedef enum logic [1:0] {DST_T0, DST_T1, DST_T2, DST_ES} dst_e;

  typedef enum logic [1:0] {RES_CLEAR, RES_FAULT, RES_DUTY} res_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_ISSUE, ST_WAIT, ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    op_e    op;
    src_e   a;
    src_e   b;
    shift_e sh;
    dst_e   dst;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic clear_es;
    logic start;
    logic wr;
    logic load_out;
    res_e res;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic clear_req;
    logic zero_div;
    logic unit_done;
  } sts_t;

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    begin
      u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SH_0, DST_T0};
      unique case (pc)
        5'd0:  u = '{OP_MUL, SRC_VOUT, SRC_IO,   SH_0,  DST_T0};
        5'd1:  u = '{OP_DIV, SRC_T0,   SRC_VIN,  SH_0,  DST_T0};
        5'd2:  u = '{OP_MUL, SRC_T0,   SRC_T0,   SH_0,  DST_T0};
        5'd3:  u = '{OP_MUL, SRC_IND,  SRC_T0,   SH_41, DST_T0};
        5'd4:  u = '{OP_MUL, SRC_VREF, SRC_VREF, SH_0,  DST_T1};
        5'd5:  u = '{OP_MUL, SRC_CAP,  SRC_T1,   SH_41, DST_T1};
        5'd6:  u = '{OP_ADD, SRC_T1,   SRC_T0,   SH_0,  DST_T0};
        5'd7:  u = '{OP_MUL, SRC_VDO,  SRC_VDO,  SH_0,  DST_T1};
        5'd8:  u = '{OP_MUL, SRC_CAP,  SRC_T1,   SH_41, DST_T1};
        5'd9:  u = '{OP_MUL, SRC_IL,   SRC_IL,   SH_0,  DST_T2};
        5'd10: u = '{OP_MUL, SRC_IND,  SRC_T2,   SH_41, DST_T2};
        5'd11: u = '{OP_ADD, SRC_T1,   SRC_T2,   SH_0,  DST_T1};
        5'd12: u = '{OP_SUB, SRC_T0,   SRC_T1,   SH_0,  DST_T0};
        5'd13: u = '{OP_MUL, SRC_DT,   SRC_T0,   SH_40, DST_T0};
        5'd14: u = '{OP_ADD, SRC_ES,   SRC_T0,   SH_0,  DST_ES};
        5'd15: u = '{OP_MUL, SRC_VDI,  SRC_IL,   SH_0,  DST_T0};
        5'd16: u = '{OP_MUL, SRC_VDO,  SRC_IO,   SH_0,  DST_T2};
        5'd17: u = '{OP_SUB, SRC_T0,   SRC_T2,   SH_0,  DST_T0};
        5'd18: u = '{OP_MUL, SRC_K1,   SRC_T1,   SH_23, DST_T2};
        5'd19: u = '{OP_SUB, SRC_ZERO, SRC_T2,   SH_0,  DST_T2};
        5'd20: u = '{OP_MUL, SRC_K2,   SRC_T0,   SH_23, DST_T0};
        5'd21: u = '{OP_SUB, SRC_T2,   SRC_T0,   SH_0,  DST_T2};
        5'd22: u = '{OP_MUL, SRC_K3,   SRC_ES,   SH_23, DST_T0};
        5'd23: u = '{OP_SUB, SRC_T2,   SRC_T0,   SH_0,  DST_T2};
        5'd24: u = '{OP_MUL, SRC_IND,  SRC_T2,   SH_40, DST_T2};
        5'd25: u = '{OP_DIV, SRC_T2,   SRC_VDI,  SH_0,  DST_T2};
        5'd26: u = '{OP_SUB, SRC_VDI,  SRC_T2,   SH_0,  DST_T2};
        5'd27: u = '{OP_MUL, SRC_T2,   SRC_ONE,  SH_0,  DST_T2};
        5'd28: u = '{OP_DIV, SRC_T2,   SRC_VDO,  SH_0,  DST_T2};
        default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, SH_0, DST_T0};
      endcase
      return u;
    end
  endfunction

endpackage

### design/boost_energy_integral_duty_control_unit.sv
// ----------------------------------------------------------------------------
// boost_energy_integral_duty_control_unit
// Energy-based integral duty controller for a boost converter.
// ----------------------------------------------------------------------------
// channel | direction | handshake                  | payload
// in      | in        | in_valid_i / in_ready_o    | seven Q10.14 values, clear flag
// out     | out       | out_valid_o / out_ready_i  | duty_o, fault_o
// cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A full control step runs 17 products on the shared multiplier (one 32x32
// partial product at a time), 3 quotients on the bit-serial divider and 9
// add/subtract steps, plus capture, check and result load. Clear and fault
// items skip the micro-program and go from the check to the result load.
// One item is in flight at a time; the result register frees the input
// side, and a stalled result holds the next item in the last step.
// Reset loads the register defaults and zeroes the integrator.
module boost_energy_integral_duty_control_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [23:0]           load_side_voltage_i,
  input  logic signed [23:0]           source_side_voltage_i,
  input  logic signed [23:0]           link_output_voltage_i,
  input  logic signed [23:0]           link_input_voltage_i,
  input  logic signed [23:0]           coil_current_i,
  input  logic signed [23:0]           load_current_i,
  input  logic signed [23:0]           target_voltage_i,
  input  logic                         clear_integrator_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  duty_o,
  output logic                         fault_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [beidc_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                  cfg_data_i
);
  import beidc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  beidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  beidc_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .load_side_voltage_i   (load_side_voltage_i),
    .source_side_voltage_i (source_side_voltage_i),
    .link_output_voltage_i (link_output_voltage_i),
    .link_input_voltage_i  (link_input_voltage_i),
    .coil_current_i        (coil_current_i),
    .load_current_i        (load_current_i),
    .target_voltage_i      (target_voltage_i),
    .clear_integrator_i    (clear_integrator_i),
    .duty_o                (duty_o),
    .fault_o               (fault_o)
  );

endmodule

### design/beidc_mul.sv
// ----------------------------------------------------------------------------
// beidc_mul
// Sequential 64x64 signed multiplier with rounding shift and saturation.
// ----------------------------------------------------------------------------
module beidc_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [63:0]        a_i,
  input  logic signed [63:0]        b_i,
  input  beidc_pkg::shift_e         sh_i,
  output logic                      done_o,
  output logic signed [63:0]        res_o
);
  import beidc_pkg::*;

  logic              active_q, done_q;
  logic [2:0]        step_q;
  logic [63:0]       x_q, y_q;
  logic              neg_q;
  shift_e            sh_q;
  logic [127:0]      acc_q, acc_d;
  logic [31:0]       xs, ys;
  logic [63:0]       pp;
  logic [127:0]      rnd, shifted;
  logic [63:0]       lim, mag;
  logic signed [63:0] res_q;

  assign xs = step_q[1] ? x_q[63:32] : x_q[31:0];
  assign ys = step_q[0] ? y_q[63:32] : y_q[31:0];
  assign pp = {32'd0, xs} * {32'd0, ys};

  always_comb begin
    case (sh_q)
      SH_23:   rnd = 128'd1 << 22;
      SH_40:   rnd = 128'd1 << 39;
      SH_41:   rnd = 128'd1 << 40;
      default: rnd = '0;
    endcase
    case (sh_q)
      SH_23:   shifted = acc_q >> 23;
      SH_40:   shifted = acc_q >> 40;
      SH_41:   shifted = acc_q >> 41;
      default: shifted = acc_q;
    endcase
    case (step_q)
      3'd0:    acc_d = acc_q + {64'd0, pp};
      3'd1,
      3'd2:    acc_d = acc_q + {32'd0, pp, 32'd0};
      3'd3:    acc_d = acc_q + {pp, 64'd0};
      3'd4:    acc_d = acc_q + rnd;
      default: acc_d = acc_q;
    endcase
    lim = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    mag = ((shifted[127:64] != 64'd0) || (shifted[63:0] > lim)) ? lim : shifted[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        step_q   <= '0;
      end else if (active_q) begin
        if (step_q == 3'd5) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      y_q   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      sh_q  <= sh_i;
      acc_q <= '0;
    end else if (active_q) begin
      acc_q <= acc_d;
      if (step_q == 3'd5) begin
        res_q <= neg_q ? -$signed(mag) : $signed(mag);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### design/beidc_div.sv
// ----------------------------------------------------------------------------
// beidc_div
// Restoring 64-bit signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module beidc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);
  import beidc_pkg::*;

  logic              active_q, fin_q, done_q;
  logic [5:0]        cnt_q;
  logic [63:0]       n_q, d_q;
  logic [64:0]       rem_q, trial, rem_d;
  logic              qbit, neg_q, spec_q;
  logic signed [63:0] res_q;

  assign trial = {rem_q[63:0], n_q[63]};
  assign qbit  = trial >= {1'b0, d_q};
  assign rem_d = qbit ? (trial - {1'b0, d_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      fin_q    <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          active_q <= 1'b0;
          fin_q    <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      d_q    <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      rem_q  <= '0;
      neg_q  <= a_i[63] ^ b_i[63];
      spec_q <= (a_i == W_MIN) && (b_i == -64'sd1);
    end else if (active_q) begin
      rem_q <= rem_d;
      n_q   <= {n_q[62:0], qbit};
    end else if (fin_q) begin
      res_q <= spec_q ? W_MAX : (neg_q ? -$signed(n_q) : $signed(n_q));
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### design/beidc_dp.sv
// ----------------------------------------------------------------------------
// beidc_dp
// Datapath: registers, operand selection, saturating adder, shared units.
// ----------------------------------------------------------------------------
module beidc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  beidc_pkg::cmd_t                  cmd_i,
  output beidc_pkg::sts_t                  sts_o,
  input  logic                             cfg_valid_i,
  input  logic [beidc_pkg::IDX_W-1:0]      cfg_index_i,
  input  logic [63:0]                      cfg_data_i,
  input  logic signed [23:0]               load_side_voltage_i,
  input  logic signed [23:0]               source_side_voltage_i,
  input  logic signed [23:0]               link_output_voltage_i,
  input  logic signed [23:0]               link_input_voltage_i,
  input  logic signed [23:0]               coil_current_i,
  input  logic signed [23:0]               load_current_i,
  input  logic signed [23:0]               target_voltage_i,
  input  logic                             clear_integrator_i,
  output logic [beidc_pkg::DUTY_W-1:0]     duty_o,
  output logic                             fault_o
);
  import beidc_pkg::*;

  logic signed [63:0] k1_q, k2_q, k3_q, es_q;
  logic [CFG_W-1:0]   dt_q, cap_q, ind_q;
  logic signed [23:0] vout_q, vin_q, vdo_q, vdi_q, il_q, io_q, vref_q;
  logic               clr_q;
  logic signed [63:0] t0_q, t1_q, t2_q;
  logic [DUTY_W-1:0]  duty_q;
  logic               fault_q;

  logic signed [63:0] opa, opb, beff, sum, add_res, wr_val;
  logic signed [63:0] mul_res, div_res;
  logic               mul_done, div_done, ovf;
  logic [DUTY_W-1:0]  duty_calc;

  function automatic logic signed [63:0] pick(input src_e s,
      input logic signed [63:0] t0, input logic signed [63:0] t1,
      input logic signed [63:0] t2, input logic signed [63:0] es,
      input logic signed [63:0] k1, input logic signed [63:0] k2,
      input logic signed [63:0] k3, input logic [CFG_W-1:0] dt,
      input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] ind,
      input logic signed [23:0] vout, input logic signed [23:0] vin,
      input logic signed [23:0] vdo, input logic signed [23:0] vdi,
      input logic signed [23:0] il, input logic signed [23:0] io,
      input logic signed [23:0] vref);
    logic signed [63:0] r;
    begin
      unique case (s)
        SRC_T0:   r = t0;
        SRC_T1:   r = t1;
        SRC_T2:   r = t2;
        SRC_ES:   r = es;
        SRC_ZERO: r = '0;
        SRC_ONE:  r = {48'd0, DUTY_ONE};
        SRC_VOUT: r = {{40{vout[23]}}, vout};
        SRC_VIN:  r = {{40{vin[23]}}, vin};
        SRC_VDO:  r = {{40{vdo[23]}}, vdo};
        SRC_VDI:  r = {{40{vdi[23]}}, vdi};
        SRC_IL:   r = {{40{il[23]}}, il};
        SRC_IO:   r = {{40{io[23]}}, io};
        SRC_VREF: r = {{40{vref[23]}}, vref};
        SRC_K1:   r = k1;
        SRC_K2:   r = k2;
        SRC_K3:   r = k3;
        SRC_DT:   r = {24'd0, dt};
        SRC_CAP:  r = {24'd0, cap};
        SRC_IND:  r = {24'd0, ind};
        default:  r = '0;
      endcase
      return r;
    end
  endfunction

  always_comb begin
    opa = pick(cmd_i.uop.a, t0_q, t1_q, t2_q, es_q, k1_q, k2_q, k3_q, dt_q, cap_q,
               ind_q, vout_q, vin_q, vdo_q, vdi_q, il_q, io_q, vref_q);
    opb = pick(cmd_i.uop.b, t0_q, t1_q, t2_q, es_q, k1_q, k2_q, k3_q, dt_q, cap_q,
               ind_q, vout_q, vin_q, vdo_q, vdi_q, il_q, io_q, vref_q);
    if (cmd_i.uop.op == OP_SUB) begin
      beff = (opb == W_MIN) ? W_MAX : -opb;
    end else begin
      beff = opb;
    end
    sum     = opa + beff;
    ovf     = (opa[63] == beff[63]) && (sum[63] != opa[63]);
    add_res = ovf ? (opa[63] ? W_MIN : W_MAX) : sum;
    unique case (cmd_i.uop.op)
      OP_MUL:  wr_val = mul_res;
      OP_DIV:  wr_val = div_res;
      default: wr_val = add_res;
    endcase
    if (t2_q <= 64'sd0) begin
      duty_calc = DUTY_ONE;
    end else if (t2_q >= $signed({48'd0, DUTY_ONE})) begin
      duty_calc = '0;
    end else begin
      duty_calc = DUTY_ONE - t2_q[DUTY_W-1:0];
    end
  end

  beidc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && (cmd_i.uop.op == OP_MUL)),
    .a_i     (opa),
    .b_i     (opb),
    .sh_i    (cmd_i.uop.sh),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  beidc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && (cmd_i.uop.op == OP_DIV)),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q  <= K1_RST;
      k2_q  <= K2_RST;
      k3_q  <= K3_RST;
      dt_q  <= DT_RST;
      cap_q <= CAP_RST;
      ind_q <= IND_RST;
      es_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_K1:  k1_q  <= cfg_data_i;
          CFG_K2:  k2_q  <= cfg_data_i;
          CFG_K3:  k3_q  <= cfg_data_i;
          CFG_DT:  dt_q  <= cfg_data_i[CFG_W-1:0];
          CFG_CAP: cap_q <= cfg_data_i[CFG_W-1:0];
          CFG_IND: ind_q <= cfg_data_i[CFG_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear_es) begin
        es_q <= '0;
      end else if (cmd_i.wr && (cmd_i.uop.dst == DST_ES)) begin
        es_q <= wr_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vout_q <= load_side_voltage_i;
      vin_q  <= source_side_voltage_i;
      vdo_q  <= link_output_voltage_i;
      vdi_q  <= link_input_voltage_i;
      il_q   <= coil_current_i;
      io_q   <= load_current_i;
      vref_q <= target_voltage_i;
      clr_q  <= clear_integrator_i;
    end
    if (cmd_i.wr) begin
      case (cmd_i.uop.dst)
        DST_T0:  t0_q <= wr_val;
        DST_T1:  t1_q <= wr_val;
        DST_T2:  t2_q <= wr_val;
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      case (cmd_i.res)
        RES_DUTY: begin
          duty_q  <= duty_calc;
          fault_q <= 1'b0;
        end
        RES_FAULT: begin
          duty_q  <= '0;
          fault_q <= 1'b1;
        end
        default: begin
          duty_q  <= '0;
          fault_q <= 1'b0;
        end
      endcase
    end
  end

  assign sts_o.clear_req = clr_q;
  assign sts_o.zero_div  = (vin_q == 24'sd0) || (vdo_q == 24'sd0) || (vdi_q == 24'sd0);
  assign sts_o.unit_done = mul_done || div_done;
  assign duty_o          = duty_q;
  assign fault_o         = fault_q;

endmodule

### design/beidc_ctrl.sv
// ----------------------------------------------------------------------------
// beidc_ctrl
// Controller: handshakes and the micro-program sequencer.
// ----------------------------------------------------------------------------
module beidc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  beidc_pkg::sts_t sts_i,
  output beidc_pkg::cmd_t cmd_o
);
  import beidc_pkg::*;

  ctl_state_e       state_q, state_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  res_e             res_q, res_d;
  logic             out_valid_q;
  uop_t             uop;
  logic             is_alu, out_free;

  assign uop      = uop_rom(pc_q);
  assign is_alu   = (uop.op == OP_ADD) || (uop.op == OP_SUB);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        pc_d = '0;
        if (sts_i.clear_req) begin
          res_d   = RES_CLEAR;
          state_d = ST_FINISH;
        end else if (sts_i.zero_div) begin
          res_d   = RES_FAULT;
          state_d = ST_FINISH;
        end else begin
          res_d   = RES_DUTY;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (is_alu) begin
          pc_d    = pc_q + 5'd1;
          state_d = (pc_q == LAST_PC) ? ST_FINISH : ST_ISSUE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts_i.unit_done) begin
          pc_d    = pc_q + 5'd1;
          state_d = (pc_q == LAST_PC) ? ST_FINISH : ST_ISSUE;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.uop      = uop;
    cmd_o.res      = res_q;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clear_es = (state_q == ST_CHECK) && sts_i.clear_req;
    cmd_o.start    = (state_q == ST_ISSUE) && !is_alu;
    cmd_o.wr       = ((state_q == ST_ISSUE) && is_alu) ||
                     ((state_q == ST_WAIT) && sts_i.unit_done);
    cmd_o.load_out = (state_q == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      res_q       <= RES_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      res_q   <= res_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/beidc_checker.sv
// ----------------------------------------------------------------------------
// beidc_checker
// Port-level checks on the energy duty controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "boost_energy_integral_duty_control_unit_macros.svh"

module beidc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [15:0]                  duty_o,
  input logic                         fault_o
);
  import beidc_pkg::*;

  `BEIDC_ASSERT_IMPL(a_duty_range, clk_i, rst_ni, out_valid_o, duty_o <= DUTY_ONE)
  `BEIDC_ASSERT_IMPL(a_fault_duty, clk_i, rst_ni, out_valid_o && fault_o, duty_o == '0)
  `BEIDC_ASSERT_NEXT(a_busy_after_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `BEIDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(duty_o) && $stable(fault_o))

endmodule

bind boost_energy_integral_duty_control_unit beidc_checker u_beidc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .duty_o      (duty_o),
  .fault_o     (fault_o)
);

### tb/boost_energy_integral_duty_control_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy duty controller testbench
// Drives measurement items with random idling, writes every register over
// several settings, and checks each duty/fault result against a
// bit-exact fixed-point model of the control step.
// ----------------------------------------------------------------------------
module boost_energy_integral_duty_control_unit_tb;
  import beidc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef logic signed [63:0] word_t;

  typedef struct packed {
    logic signed [23:0] vout;
    logic signed [23:0] vin;
    logic signed [23:0] vdo;
    logic signed [23:0] vdi;
    logic signed [23:0] il;
    logic signed [23:0] io;
    logic signed [23:0] vref;
    logic               clr;
  } meas_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        fault;
  } duty_res_t;

  class duty_scoreboard;
    word_t       k_energy, k_rate, k_integral;
    logic [39:0] dt, cap, ind;
    word_t       error_sum;
    duty_res_t   expected_duty_q[$];
    int          errors;

    function new();
      k_energy   = K1_RST;
      k_rate     = K2_RST;
      k_integral = K3_RST;
      dt         = DT_RST;
      cap        = CAP_RST;
      ind        = IND_RST;
      error_sum  = '0;
      errors     = 0;
    endfunction

    function automatic word_t scaled_prod(word_t a, word_t b, int sh);
      logic [63:0]  ma, mb;
      logic [127:0] p, lim;
      logic         neg;
      neg = a[63] ^ b[63];
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      p = {64'd0, ma} * {64'd0, mb};
      if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
      lim = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
      if (p > lim) p = lim;
      return neg ? -p[63:0] : p[63:0];
    endfunction

    function automatic word_t sat_add(word_t a, word_t b);
      logic signed [64:0] s;
      s = a + b;
      if (s > W_MAX) return W_MAX;
      if (s < W_MIN) return W_MIN;
      return s[63:0];
    endfunction

    function automatic word_t sat_neg(word_t a);
      return (a == W_MIN) ? W_MAX : -a;
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
      return sat_add(a, sat_neg(b));
    endfunction

    function automatic word_t sat_div(word_t a, word_t b);
      if (a == W_MIN && b == -64'sd1) return W_MAX;
      return a / b;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_K1:  k_energy = data;
        CFG_K2:  k_rate = data;
        CFG_K3:  k_integral = data;
        CFG_DT:  dt = data[39:0];
        CFG_CAP: cap = data[39:0];
        CFG_IND: ind = data[39:0];
        default: ;
      endcase
    endfunction

    function void note_item(meas_t m);
      word_t     vout, vin, vdo, vdi, il, io, vref, c, l, ilr, yr, y, ydot, v, t, q;
      duty_res_t r;
      vout = m.vout; vin = m.vin; vdo = m.vdo; vdi = m.vdi;
      il = m.il; io = m.io; vref = m.vref;
      c = {24'd0, cap};
      l = {24'd0, ind};
      r = '0;
      if (m.clr) begin
        error_sum = '0;
      end else if (vin == 0 || vdo == 0 || vdi == 0) begin
        r.fault = 1'b1;
      end else begin
        ilr = (vout * io) / vin;
        yr = sat_add(scaled_prod(c, vref * vref, 41),
                     scaled_prod(l, scaled_prod(ilr, ilr, 0), 41));
        y = sat_add(scaled_prod(c, vdo * vdo, 41), scaled_prod(l, il * il, 41));
        ydot = vdi * il - vdo * io;
        error_sum = sat_add(error_sum, scaled_prod({24'd0, dt}, sat_sub(yr, y), 40));
        v = sat_neg(scaled_prod(k_energy, y, 23));
        v = sat_sub(v, scaled_prod(k_rate, ydot, 23));
        v = sat_sub(v, scaled_prod(k_integral, error_sum, 23));
        t = sat_sub(vdi, sat_div(scaled_prod(l, v, 40), vdi));
        q = sat_div(scaled_prod(t, 64'sd32768, 0), vdo);
        if (q <= 0) r.duty = DUTY_ONE;
        else if (q >= 32768) r.duty = '0;
        else r.duty = 16'(32768 - q);
      end
      expected_duty_q.push_back(r);
    endfunction

    task report(string what);
      $display("%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [15:0] duty, logic fault);
      duty_res_t e;
      if (expected_duty_q.size() == 0) begin
        report($sformatf("unexpected result duty=%0d fault=%0b", duty, fault));
        return;
      end
      e = expected_duty_q.pop_front();
      if (duty !== e.duty) report($sformatf("duty %0d, want %0d", duty, e.duty));
      if (fault !== e.fault) report($sformatf("fault %0b, want %0b", fault, e.fault));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] load_side_voltage_i = '0;
  logic signed [23:0] source_side_voltage_i = '0;
  logic signed [23:0] link_output_voltage_i = '0;
  logic signed [23:0] link_input_voltage_i = '0;
  logic signed [23:0] coil_current_i = '0;
  logic signed [23:0] load_current_i = '0;
  logic signed [23:0] target_voltage_i = '0;
  logic               clear_integrator_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        duty_o;
  logic               fault_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [IDX_W-1:0]   cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;

  duty_scoreboard sb = new();
  int unsigned    cycles = 0;
  int             in_idle_pct = 36;
  int             out_idle_pct = 36;
  bit             hold_req = 1'b0;
  int             hold_left = 0;

  boost_energy_integral_duty_control_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(duty_o, fault_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic meas_t mk(int vout, int vin, int vdo, int vdi, int il, int io,
                               int vref, bit clr);
    meas_t m;
    m = '{24'(vout), 24'(vin), 24'(vdo), 24'(vdi), 24'(il), 24'(io), 24'(vref), clr};
    return m;
  endfunction

  function automatic meas_t rand_item();
    meas_t m;
    int    sel;
    sel = $urandom_range(99);
    m = mk($urandom_range(700000, 900000), $urandom_range(300000, 500000),
           $urandom_range(700000, 900000), $urandom_range(300000, 500000),
           $urandom_range(0, 400000) - 50000, $urandom_range(0, 80000),
           $urandom_range(700000, 900000), 1'b0);
    if (sel < 25) begin
      m = {$urandom, $urandom, $urandom, $urandom, $urandom, 9'($urandom)};
      m.clr = 1'b0;
    end else if (sel < 35) begin
      m.vin = 24'($urandom_range(0, 40)) - 24'sd20;
      m.vdi = 24'($urandom_range(0, 400)) - 24'sd200;
      m.vdo = 24'($urandom_range(0, 4000)) - 24'sd2000;
    end
    if (sel >= 90 && sel < 96) begin
      case ($urandom_range(2))
        0: m.vin = '0;
        1: m.vdo = '0;
        default: m.vdi = '0;
      endcase
    end
    if (sel >= 96) m.clr = 1'b1;
    return m;
  endfunction

  task send_item(meas_t m);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    load_side_voltage_i   <= m.vout;
    source_side_voltage_i <= m.vin;
    link_output_voltage_i <= m.vdo;
    link_input_voltage_i  <= m.vdi;
    coil_current_i        <= m.il;
    load_current_i        <= m.io;
    target_voltage_i      <= m.vref;
    clear_integrator_i    <= m.clr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(m);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_duty_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task write_all(logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                 logic [63:0] dt, logic [63:0] cap, logic [63:0] ind);
    write_reg(CFG_K1, k1);
    write_reg(CFG_K2, k2);
    write_reg(CFG_K3, k3);
    write_reg(CFG_DT, dt);
    write_reg(CFG_CAP, cap);
    write_reg(CFG_IND, ind);
    cfg_valid_i <= 1'b0;
  endtask

  task run_random(int n);
    repeat (n) send_item(rand_item());
  endtask

  initial begin
    meas_t directed[$];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      mk(786432, 393216, 786432, 393216, 163840, 32768, 786432, 0),
      mk(786432, 393216, 770000, 393216, 200000, 32768, 786432, 0),
      mk(786432, 393216, 786432, 393216, 163840, 32768, 786432, 1),
      mk(786432, 0, 786432, 393216, 163840, 32768, 786432, 0),
      mk(786432, 393216, 0, 393216, 163840, 32768, 786432, 0),
      mk(786432, 393216, 786432, 0, 163840, 32768, 786432, 0),
      mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 0),
      mk(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 0),
      mk(8388607, -8388608, 8388607, -8388608, 8388607, -8388608, 8388607, 0),
      mk(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607, -8388608, 0),
      mk(8388607, -1, 1, 1, -8388608, 8388607, 0, 0),
      mk(0, 1, -1, 1, 0, 0, 0, 0),
      mk(-8388608, 1, 8388607, -1, 8388607, -8388608, -8388608, 0),
      mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 1),
      mk(786432, 393216, 786432, 393216, 163840, 32768, 786432, 0),
      mk(0, 0, 0, 0, 0, 0, 0, 1)
    };
    foreach (directed[i]) send_item(directed[i]);

    // stretch with no idling on either side, then a long output stall while items keep coming
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_random(100);
    in_idle_pct = 36;
    out_idle_pct = 36;
    hold_req = 1'b1;
    run_random(200);
    drain();

    write_reg(3'd6, {$urandom, $urandom});
    write_reg(3'd7, {$urandom, $urandom});
    write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    run_random(230);
    drain();

    write_all(W_MAX, W_MAX, W_MAX, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    run_random(150);
    drain();

    write_all(W_MIN, W_MIN, W_MIN, '0, '0, '0);
    run_random(150);
    drain();

    write_all(K1_RST, K2_RST, K3_RST, 64'(DT_RST), 64'(CAP_RST), 64'(IND_RST));
    run_random(200);
    drain();

    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_duty_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### boost_energy_integral_duty_control_unit.f
+incdir+design
design/beidc_pkg.sv
design/beidc_mul.sv
design/beidc_div.sv
design/beidc_dp.sv
design/beidc_ctrl.sv
design/boost_energy_integral_duty_control_unit.sv
design/beidc_checker.sv
tb/boost_energy_integral_duty_control_unit_tb.sv
